/* hw/rtl/memory_test_pattern_sequencer_macros.svh */
// Assertion macros for the memory test pattern sequencer.
`ifndef MEMORY_TEST_PATTERN_SEQUENCER_MACROS_SVH
`define MEMORY_TEST_PATTERN_SEQUENCER_MACROS_SVH
// Implication checked every clock outside reset.
`define MTPS_ASSERT_IMP(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define MTPS_ASSERT_NXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/mtps_pkg.sv */
// Package: codes, types and pattern tables of the memory test pattern sequencer.
package mtps_pkg;
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_RUN  = 2'd1;
	localparam logic [1:0] RS_PASS = 2'd2;
	localparam logic [1:0] RS_FAIL = 2'd3;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_START   = 1'b1;

	localparam logic [0:0] CFG_WORD_COUNT = 1'd0;
	localparam logic [0:0] CFG_LOOP_COUNT = 1'd1;

	localparam logic [4:0] T_ZEROS   = 5'd0;
	localparam logic [4:0] T_ONES    = 5'd1;
	localparam logic [4:0] T_ADDR    = 5'd2;
	localparam logic [4:0] T_CHECKER = 5'd3;
	localparam logic [4:0] T_WALK1   = 5'd4;
	localparam logic [4:0] T_WALK0   = 5'd5;
	localparam logic [4:0] T_STRESS  = 5'd6;

	localparam int ROM_ROWS = 22;

	typedef logic [31:0] word_t;
	typedef logic [31:0] rom_row_t [8];

	function automatic word_t stress_word(input logic [4:0] row, input logic [2:0] col);
		word_t r [ROM_ROWS][8];
		r[0]  = '{32'h00000000,32'h00000000,32'hFFFFFFFF,32'hFFFFFFFF,
		          32'h00000000,32'h00000000,32'hFFFFFFFF,32'hFFFFFFFF};
		r[1]  = '{32'hFFFFFFFF,32'hFFFFFFFF,32'h00000000,32'h00000000,
		          32'hFFFFFFFF,32'hFFFFFFFF,32'h00000000,32'h00000000};
		r[2]  = '{32'h00000000,32'hFFFFFFFF,32'h00000000,32'hFFFFFFFF,
		          32'h00000000,32'hFFFFFFFF,32'h00000000,32'hFFFFFFFF};
		r[3]  = '{32'hFFFFFFFF,32'h00000000,32'hFFFFFFFF,32'h00000000,
		          32'hFFFFFFFF,32'h00000000,32'hFFFFFFFF,32'h00000000};
		r[4]  = '{32'h55555555,32'h55555555,32'hAAAAAAAA,32'hAAAAAAAA,
		          32'h55555555,32'h55555555,32'hAAAAAAAA,32'hAAAAAAAA};
		r[5]  = '{32'hAAAAAAAA,32'hAAAAAAAA,32'h55555555,32'h55555555,
		          32'hAAAAAAAA,32'hAAAAAAAA,32'h55555555,32'h55555555};
		r[6]  = '{32'h55555555,32'hAAAAAAAA,32'h55555555,32'hAAAAAAAA,
		          32'h55555555,32'hAAAAAAAA,32'h55555555,32'hAAAAAAAA};
		r[7]  = '{32'hAAAAAAAA,32'h55555555,32'hAAAAAAAA,32'h55555555,
		          32'hAAAAAAAA,32'h55555555,32'hAAAAAAAA,32'h55555555};
		r[8]  = '{32'h4F3F58BB,32'h0F057388,32'h175344D6,32'h7AC02A31,
		          32'h788C0726,32'h7206FA35,32'h61991C03,32'h1A5825AE};
		r[9]  = '{32'h13F33EBB,32'h05160844,32'h647C7CA7,32'h62CA545E,
		          32'h4A0BBBB5,32'h759AEB84,32'h306784A8,32'h568F3BB1};
		r[10] = '{32'h574F6AD7,32'h5A43D12D,32'h607DCDA9,32'h372DD4B6,
		          32'h2C62F31D,32'h79585232,32'h259662C5,32'h20A8C821};
		r[11] = '{32'h3D5AE3FB,32'h26A4D773,32'h684E5BAB,32'h0D27BF9B,
		          32'h214825B8,32'h08F9F903,32'h1B9CE5D3,32'h7782B195};
		r[12] = '{32'h700955DD,32'h1C478274,32'h6279CE44,32'h7DD6B77B,
		          32'h06D8FA1D,32'h0A420E67,32'h1FEBBFD7,32'h1946BF32};
		r[13] = '{32'h378A2F3B,32'h55B88A16,32'h3A7BECAE,32'h79DCB8ED,
		          32'h1C5D64CB,32'h429E1353,32'h5BB4EADC,32'h04462236};
		r[14] = '{32'h27E0DA67,32'h0AB4DCAE,32'h4F53412F,32'h60AE19F9,
		          32'h64776FF6,32'h624B5CF1,32'h052CA8DA,32'h659FF640};
		r[15] = '{32'h715B75FB,32'h42C4F032,32'h30B36009,32'h1732C5D8,
		          32'h0FB1333A,32'h502B04AD,32'h325D1C36,32'h1CAF227A};
		r[16] = '{32'h10C090EC,32'h7E5B3E58,32'h7AAF9E3C,32'h0D179A9A,
		          32'h1A100ED3,32'h7EF0821C,32'h29D683A2,32'h0A06AF2E};
		r[17] = '{32'h02D449E7,32'h5C722844,32'h3CC55B62,32'h41EBF8E2,
		          32'h3053D85B,32'h56B8C9BD,32'h2985E146,32'h4044490F};
		r[18] = '{32'h58D9B45B,32'h6ACD8547,32'h1021E2D3,32'h69D2A9DB,
		          32'h58880654,32'h4AA79971,32'h2E765731,32'h4FDA6E71};
		r[19] = '{32'h2DB64C7B,32'h50088F2D,32'h4007CDEB,32'h36044D9A,
		          32'h52245979,32'h3D109A29,32'h0B6CA5AD,32'h46874F74};
		r[20] = '{32'h600288EF,32'h469D3B9B,32'h66B48119,32'h224D10D1,
		          32'h58711BBF,32'h189FDF2C,32'h6B621B06,32'h7664A97A};
		r[21] = '{32'h6841DC7B,32'h308502E0,32'h69611211,32'h3D2EF47A,
		          32'h77F227D8,32'h38670C94,32'h5C29E723,32'h184EA713};
		return r[row][col];
	endfunction
endpackage

/* hw/rtl/memory_test_pattern_sequencer.sv */
// Top level: memory self-test sequencer driving one access per beat.
// Each input beat either starts a run (cmd=1) or advances by one RAM access; each
// input beat yields exactly one output beat carrying the access (mem_op, address,
// write data) plus run status. Reads return their data on the next advance beat,
// where it is compared with the expected word. Sub-tests: zeros, ones, address,
// four checkerboard variants, walking one, walking zero, then STRESS_ROWS 8-word
// ROM patterns (whole 8-word groups only); every sub-test writes all words then
// reads them back. A mismatch stops the run with the failing test group. Throughput
// is one beat per clock while m_tready holds: the step logic sits between the state
// registers and a single output register, and a new beat is taken while the output
// register drains. Output comes the cycle after input. No clearing pass is needed.
module memory_test_pattern_sequencer #(
	parameter int DEPTH       = 65536,
	parameter int STRESS_ROWS = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] cmd, [32:1] read_data, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [1:0] mem_op, [17:2] mem_addr, [49:18] mem_wdata,
	                               // [51:50] run_state, [56:52] failed_test,
	                               // [62:57] progress, [78:63] loop_index, rest zero
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);
	import mtps_pkg::*;

	// Effective clamp on word count, fixed by DEPTH.
	localparam int      MAXW     = (DEPTH < 65536) ? DEPTH : 65536;
	localparam logic [16:0] MAXW_C = 17'(MAXW);
	// Test index runs past 31 when there are many stress rows, so it is 6 bits.
	localparam logic [5:0] LAST_TEST = 6'(6 + STRESS_ROWS);

	logic [16:0] word_count_q;
	logic [15:0] loop_count_q;
	logic [5:0]  test_q;
	logic [1:0]  sub_q;
	logic        rphase_q;
	logic [15:0] addr_q;
	logic [31:0] exp_q;
	logic        pend_q;
	logic [15:0] loops_q;
	logic [5:0]  prog_q;
	logic [1:0]  stat_q;
	logic [4:0]  fail_q;

	logic        acc;
	assign s_tready = !m_tvalid || m_tready;
	assign acc = s_tvalid && s_tready;

	logic        in_cmd;
	logic [31:0] in_rd;
	assign in_cmd = s_tdata[0];
	assign in_rd  = s_tdata[32:1];

	// Stress rows wrap by one subtraction of ROM_ROWS: modulo the ROM size below 2*ROM_ROWS.
	function automatic logic [4:0] rom_row(input logic [5:0] t);
		logic [5:0] r;
		r = t - 6'(T_STRESS);
		if (r >= 6'(ROM_ROWS)) r = r - 6'(ROM_ROWS);
		return r[4:0];
	endfunction

	function automatic logic [31:0] pattern(input logic [5:0] t, input logic [1:0] s,
	                                         input logic [15:0] a);
		logic [31:0] bitv;
		bitv = 32'd1 << a[4:0];
		priority case (1'b1)
			t == T_ZEROS:   return 32'h0;
			t == T_ONES:    return 32'hFFFFFFFF;
			t == T_ADDR:    return {16'h0, a};
			t == T_CHECKER: begin
				unique case (s)
					2'd0: return a[0] ? 32'h55555555 : 32'hAAAAAAAA;
					2'd1: return a[0] ? 32'hAAAAAAAA : 32'h55555555;
					2'd2: return a[0] ? 32'h00000000 : 32'hFFFFFFFF;
					default: return a[0] ? 32'hFFFFFFFF : 32'h00000000;
				endcase
			end
			t == T_WALK1:   return bitv;
			t == T_WALK0:   return ~bitv;
			default:        return stress_word(rom_row(t), a[2:0]);
		endcase
	endfunction

	// Clamped word count, rounded down to a multiple of 8 for stress tests.
	function automatic logic [16:0] words_in(input logic [5:0] t, input logic [16:0] wc);
		logic [16:0] n;
		n = wc;
		if (n < 17'd8) n = 17'd8;
		if (n > MAXW_C) n = MAXW_C;
		if (t >= T_STRESS) n[2:0] = 3'd0;
		return n;
	endfunction

	typedef struct packed {
		logic [5:0]  test;
		logic [1:0]  sub;
		logic        rphase;
		logic [15:0] addr;
		logic        done;
	} pos_t;

	function automatic pos_t step(input pos_t p, input logic [16:0] wc);
		pos_t o;
		o = p;
		o.done = 1'b0;
		if ({1'b0, p.addr} + 17'd1 < words_in(p.test, wc)) begin
			o.addr = p.addr + 16'd1;
		end else if (!p.rphase) begin
			o.rphase = 1'b1;
			o.addr = '0;
		end else begin
			o.rphase = 1'b0;
			o.addr = '0;
			if (p.test == T_CHECKER && p.sub < 2'd3) begin
				o.sub = p.sub + 2'd1;
			end else begin
				o.sub = '0;
				o.test = p.test + 6'd1;
			end
			o.done = 1'b1;
		end
		return o;
	endfunction

	// Next-state computation.
	pos_t        p_n, p_adv;
	logic [31:0] exp_n;
	logic        pend_n;
	logic [15:0] loops_n;
	logic [5:0]  prog_n;
	logic [1:0]  stat_n;
	logic [4:0]  fail_n;
	logic        issue;
	logic [1:0]  op_n;
	logic [15:0] oaddr_n;
	logic [31:0] wdata_n;
	logic [31:0] pat;

	always_comb begin
		p_n     = '{test: test_q, sub: sub_q, rphase: rphase_q, addr: addr_q, done: 1'b0};
		exp_n   = exp_q;
		pend_n  = pend_q;
		loops_n = loops_q;
		prog_n  = prog_q;
		stat_n  = stat_q;
		fail_n  = fail_q;
		issue   = 1'b0;
		p_adv   = step(p_n, word_count_q);
		if (in_cmd == CMD_START) begin
			pend_n  = 1'b0;
			exp_n   = '0;
			loops_n = '0;
			fail_n  = '0;
			p_n     = '0;
			prog_n  = 6'd1;
			if (loop_count_q == '0) begin
				stat_n = RS_PASS;
				prog_n = '0;
			end else begin
				stat_n = RS_RUN;
				issue  = 1'b1;
			end
		end else if (stat_q == RS_RUN) begin
			issue = 1'b1;
			if (pend_q) begin
				pend_n = 1'b0;
				if (in_rd != exp_q) begin
					stat_n = RS_FAIL;
					// failed_test carries the low 5 bits of the group
					fail_n = test_q[4:0];
					issue  = 1'b0;
				end else begin
					p_n = p_adv;
					if (p_adv.done) begin
						prog_n = prog_q + 6'd1;
						if (p_adv.test >= LAST_TEST) begin
							loops_n = loops_q + 16'd1;
							if (loops_n >= loop_count_q) begin
								stat_n = RS_PASS;
								issue  = 1'b0;
							end else begin
								p_n    = '0;
								prog_n = 6'd1;
							end
						end
					end
				end
			end
		end
		pat     = pattern(p_n.test, p_n.sub, p_n.addr);
		op_n    = OP_NONE;
		oaddr_n = '0;
		wdata_n = '0;
		if (issue) begin
			oaddr_n = p_n.addr;
			if (!p_n.rphase) begin
				op_n    = OP_WRITE;
				wdata_n = pat;
				p_n     = step(p_n, word_count_q);
			end else begin
				op_n   = OP_READ;
				exp_n  = pat;
				pend_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= 17'd65536;
			loop_count_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WORD_COUNT: word_count_q <= cfg_wdata;
				default:        loop_count_q <= cfg_wdata[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_q   <= '0;
			sub_q    <= '0;
			rphase_q <= 1'b0;
			addr_q   <= '0;
			exp_q    <= '0;
			pend_q   <= 1'b0;
			loops_q  <= '0;
			prog_q   <= '0;
			stat_q   <= RS_IDLE;
			fail_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (acc) begin
				test_q   <= p_n.test;
				sub_q    <= p_n.sub;
				rphase_q <= p_n.rphase;
				addr_q   <= p_n.addr;
				exp_q    <= exp_n;
				pend_q   <= pend_n;
				loops_q  <= loops_n;
				prog_q   <= prog_n;
				stat_q   <= stat_n;
				fail_q   <= fail_n;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Output register (payload, no reset).
	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata <= {1'b0, loops_n, prog_n, fail_n, stat_n, wdata_n, oaddr_n, op_n};
		end
	end

	`include "memory_test_pattern_sequencer_macros.svh"

	`MTPS_ASSERT_IMP(a_op_legal, clk, arst_n, m_tvalid, m_tdata[1:0] != 2'd3, "bad mem_op")
	`MTPS_ASSERT_IMP(a_pend_run, clk, arst_n, pend_q, stat_q == RS_RUN, "read pending idle")
	`MTPS_ASSERT_NXT(a_read_pend, clk, arst_n, acc && op_n == OP_READ, pend_q,
		"read issued without pending check")
endmodule

/* tb/memory_test_pattern_sequencer_checker.sv */
// Checker: predicts each output beat of the memory test sequencer and compares it.
`timescale 1ns / 1ps
module memory_test_pattern_sequencer_checker
	import mtps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_wdata,
	output int          fail_count,
	output int          beats_pending
);
	localparam int LAST_TEST = 6 + 22;

	logic [16:0] cur_words;
	logic [15:0] cur_loops;
	logic [4:0]  test_idx;
	logic [1:0]  sub_idx;
	logic        reading;
	logic [31:0] addr_q;
	logic [4:0]  walk_q;
	logic [31:0] want_word;
	logic        rd_open;
	logic [15:0] loops_done;
	logic [5:0]  passed_cnt;
	logic [1:0]  state_q;
	logic [4:0]  fail_q;
	logic [79:0] beat_queue [$];

	function automatic logic [31:0] span();
		logic [31:0] n;
		n = cur_words;
		if (n < 8) n = 8;
		if (n > 65536) n = 65536;
		if (test_idx >= T_STRESS) n = n & ~32'd7;
		return n;
	endfunction

	function automatic logic [31:0] pattern_word();
		logic odd;
		logic [31:0] b;
		odd = addr_q[0];
		b = 32'd1 << walk_q;
		case (test_idx)
			T_ZEROS: return 32'h0;
			T_ONES: return 32'hFFFFFFFF;
			T_ADDR: return addr_q;
			T_CHECKER: begin
				case (sub_idx)
					2'd0: return odd ? 32'h55555555 : 32'hAAAAAAAA;
					2'd1: return odd ? 32'hAAAAAAAA : 32'h55555555;
					2'd2: return odd ? 32'h00000000 : 32'hFFFFFFFF;
					default: return odd ? 32'hFFFFFFFF : 32'h00000000;
				endcase
			end
			T_WALK1: return b;
			T_WALK0: return ~b;
			default: return stress_word(5'((test_idx - T_STRESS) % ROM_ROWS), addr_q[2:0]);
		endcase
	endfunction

	// Step to the next access; returns 1 when a sub-test finished.
	function automatic logic step_addr();
		logic done;
		done = 0;
		if (addr_q + 1 < span()) addr_q = addr_q + 1;
		else if (!reading) begin
			reading = 1;
			addr_q = 0;
		end else begin
			reading = 0;
			addr_q = 0;
			if (test_idx == T_CHECKER && sub_idx < 3) sub_idx = sub_idx + 1;
			else begin
				sub_idx = 0;
				test_idx = test_idx + 1;
			end
			done = 1;
		end
		walk_q = addr_q[4:0];
		return done;
	endfunction

	function automatic void restart();
		test_idx = 0;
		sub_idx = 0;
		reading = 0;
		addr_q = 0;
		walk_q = 0;
		passed_cnt = 1;
	endfunction

	function automatic logic [79:0] predict_access(input logic cmd, input logic [31:0] rdata);
		logic [1:0]  op;
		logic [15:0] a;
		logic [31:0] wd;
		logic        issue;
		logic        dummy;
		op = OP_NONE;
		a = 0;
		wd = 0;
		issue = 0;
		if (cmd == CMD_START) begin
			rd_open = 0;
			want_word = 0;
			loops_done = 0;
			fail_q = 0;
			restart();
			if (cur_loops == 0) begin
				state_q = RS_PASS;
				passed_cnt = 0;
			end else begin
				state_q = RS_RUN;
				issue = 1;
			end
		end else if (state_q == RS_RUN) begin
			issue = 1;
			if (rd_open) begin
				rd_open = 0;
				if (rdata != want_word) begin
					state_q = RS_FAIL;
					fail_q = test_idx;
					issue = 0;
				end else if (step_addr()) begin
					passed_cnt = passed_cnt + 1;
					if (test_idx >= LAST_TEST) begin
						loops_done = loops_done + 1;
						if (loops_done >= cur_loops) begin
							state_q = RS_PASS;
							issue = 0;
						end else restart();
					end
				end
			end
		end
		if (issue) begin
			wd = pattern_word();
			a = addr_q[15:0];
			if (!reading) begin
				op = OP_WRITE;
				dummy = step_addr();
			end else begin
				op = OP_READ;
				want_word = wd;
				wd = 0;
				rd_open = 1;
			end
		end
		return {1'b0, loops_done, passed_cnt, fail_q, state_q, wd, a, op};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [79:0] want;
		if (!arst_n) begin
			cur_words = 17'd65536;
			cur_loops = 16'd1;
			restart();
			passed_cnt = 0;
			want_word = 0;
			rd_open = 0;
			loops_done = 0;
			state_q = RS_IDLE;
			fail_q = 0;
			fail_count = 0;
			beat_queue.delete();
			beats_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WORD_COUNT) cur_words = cfg_wdata;
				else cur_loops = cfg_wdata[15:0];
			end
			if (s_tvalid && s_tready)
				beat_queue.push_back(predict_access(s_tdata[0], s_tdata[32:1]));
			if (m_tvalid && m_tready) begin
				if (beat_queue.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("unexpected output beat %h", m_tdata);
				end else begin
					want = beat_queue.pop_front();
					if (want !== m_tdata) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("mismatch: op %0d/%0d addr %h/%h wd %h/%h st %0d/%0d ft %0d/%0d pr %0d/%0d lp %0d/%0d",
								want[1:0], m_tdata[1:0], want[17:2], m_tdata[17:2],
								want[49:18], m_tdata[49:18], want[51:50], m_tdata[51:50],
								want[56:52], m_tdata[56:52], want[62:57], m_tdata[62:57],
								want[78:63], m_tdata[78:63]);
					end
				end
			end
			// Published after the edge so the stimulus side reads a settled count.
			beats_pending <= beat_queue.size();
		end
	end
endmodule

/* tb/memory_test_pattern_sequencer_test.sv */
// Testbench top: drives RAM-test commands and read data into the sequencer.
`timescale 1ns / 1ps
module memory_test_pattern_sequencer_test;
	import mtps_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [16:0] cfg_wdata;
	int          fail_count;
	int          beats_pending;

	// Model memory behind the sequencer: the testbench plays the RAM so that
	// reads normally return what was written. Injected faults flip a bit.
	logic [31:0] ram_image [int];
	logic [31:0] ram_reply;   // data for the next advance beat
	int          fault_odds;  // one corrupted read in this many (0 = none)
	int          stall_mode;

	memory_test_pattern_sequencer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	memory_test_pattern_sequencer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .beats_pending(beats_pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls on its own pattern; mode changes now and then, including
	// stretches with no stall at all.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// RAM model: track writes and prepare the reply for a read from the output beat.
	always @(posedge clk) begin
		logic [31:0] reply;
		if (!arst_n) begin
			ram_reply <= 0;
		end else if (m_tvalid && m_tready) begin
			if (m_tdata[1:0] == OP_WRITE)
				ram_image[m_tdata[17:2]] = m_tdata[49:18];
			else if (m_tdata[1:0] == OP_READ) begin
				reply = ram_image.exists(m_tdata[17:2]) ? ram_image[m_tdata[17:2]] : 0;
				if (fault_odds != 0 && $urandom_range(1, fault_odds) == 1)
					reply = reply ^ (32'd1 << $urandom_range(0, 31));
				ram_reply <= reply;
			end
		end
	end

	int burst_left;

	// Send one beat; bursts of random length with random gaps between them.
	task automatic send_beat(input logic cmd, input logic [31:0] rdata);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1;
		s_tdata <= {7'd0, rdata, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// Advance one access; read data tracks the RAM model once the previous
	// beat's output has been seen.
	task automatic advance_beat();
		s_tvalid <= 0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		send_beat(CMD_ADVANCE, ram_reply);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [16:0] val);
		s_tvalid <= 0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int n;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		fault_odds = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: advance while idle, then extremes of the inputs.
		send_beat(CMD_ADVANCE, 32'hFFFFFFFF);
		send_beat(CMD_ADVANCE, 32'h0);
		write_reg(CFG_LOOP_COUNT, 17'd0);
		send_beat(CMD_START, 32'hFFFFFFFF);   // zero loops: passes at once
		send_beat(CMD_ADVANCE, 32'h0);
		write_reg(CFG_WORD_COUNT, 17'd3);      // below minimum, clamps to 8
		write_reg(CFG_LOOP_COUNT, 17'd1);
		send_beat(CMD_START, 32'h0);
		for (int i = 0; i < 10; i++) send_beat(CMD_ADVANCE, $urandom);  // mismatch soon
		send_beat(CMD_START, 32'h0);
		send_beat(CMD_START, 32'hA5A5A5A5);    // restart while running
		for (int i = 0; i < 8; i++) advance_beat();
		send_beat(CMD_ADVANCE, 32'hFFFFFFFF);  // read of zero: wrong data

		// Full clean run of 8 words, one loop: every test, last check, pass.
		write_reg(CFG_LOOP_COUNT, 17'd1);
		send_beat(CMD_START, 32'h0);
		for (int i = 0; i < 500; i++) advance_beat();

		// Random phases over word counts (partial groups, extremes) and loop counts.
		n = 0;
		while (n < 330) begin
			case ($urandom_range(0, 5))
				0: write_reg(CFG_WORD_COUNT, 17'($urandom_range(8, 20)));
				1: write_reg(CFG_WORD_COUNT, 17'($urandom_range(0, 7)));
				2: write_reg(CFG_WORD_COUNT, 17'($urandom_range(65536, 131071)));
				default: write_reg(CFG_WORD_COUNT, 17'($urandom_range(9, 15)));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(CFG_LOOP_COUNT, 17'd0);
				1: write_reg(CFG_LOOP_COUNT, 17'd65535);
				default: write_reg(CFG_LOOP_COUNT, 17'($urandom_range(1, 3)));
			endcase
			fault_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 200);
			send_beat(CMD_START, $urandom);
			n++;
			for (int i = $urandom_range(20, 120); i > 0; i--) begin
				if ($urandom_range(0, 49) == 0) send_beat(1'($urandom_range(0, 1)), $urandom);
				else advance_beat();
				n++;
			end
		end
		s_tvalid <= 0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mtps_pkg.sv
hw/rtl/memory_test_pattern_sequencer.sv
tb/memory_test_pattern_sequencer_checker.sv
tb/memory_test_pattern_sequencer_test.sv
